// ===== src/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Opcode and status codes, controller states and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Default geometry
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths on the channels
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Request opcodes; code 7 is unused and acts as a no-op
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_CLEAR      = 3'd6
    } dq_op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_READ = 2'd2,
        S_RESP = 2'd3
    } dq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the request beat
        logic exec;     // carry out the captured request
        logic take_rd;  // latch the word read from the ring
    } dq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rd_issue; // a ring read was started this cycle
    } dq_stat_t;

endpackage

// ===== src/dq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_if: request and result channels of the double-ended queue
// Each channel carries valid, ready and its payload; a beat moves on a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface dq_req_if;
    logic                          valid;
    logic                          ready;
    logic [dq_pkg::OP_W-1:0]       opcode;
    logic [dq_pkg::WORD_W-1:0]     value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface dq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dq_pkg::WORD_W-1:0]     value_out;
    logic [dq_pkg::STATUS_W-1:0]   status;
    logic [dq_pkg::COUNT_W-1:0]    count;
    logic                          empty_res;

    modport source (output valid, output value_out, output status, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input value_out, input status, input count,
                    input empty_res, output ready);
endinterface

// ===== src/dq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram: generic single-port RAM
// One address per cycle for a write or a read; read data is registered.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer for the double-ended queue
// Takes one request beat, runs it through the datapath, waits for the ring
// read when one was started, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output dq_pkg::dq_cmd_t cmd,
    input  dq_pkg::dq_stat_t stat
);
    import dq_pkg::*;

    dq_state_t state_reg;
    dq_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.rd_issue ? S_READ : S_RESP;
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_READ:
            begin
                cmd.take_rd = 1'b1;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/dq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath: ring pointers, slot storage and result registers
// Holds the head index and fill count, drives the slot RAM and builds the
// result of each request.
// ----------------------------------------------------------------------------
module dq_datapath #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dq_pkg::dq_cmd_t               cmd,
    output dq_pkg::dq_stat_t              stat,
    input  logic [dq_pkg::OP_W-1:0]       opcode,
    input  logic [dq_pkg::WORD_W-1:0]     value_in,
    output logic [dq_pkg::WORD_W-1:0]     value_out,
    output logic [dq_pkg::STATUS_W-1:0]   status,
    output logic [dq_pkg::COUNT_W-1:0]    count,
    output logic                          empty_res
);
    import dq_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int XW  = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;
    localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    // Request registers
    dq_op_t                op_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [XW-1:0]         word_ext;

    // Queue state
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    // Result registers
    dq_status_t        status_reg;
    dq_status_t        status_next;
    logic [WORD_W-1:0] vout_reg;
    logic [WORD_W-1:0] vout_next;

    // Ring access
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [XW-1:0]         rdata_ext;

    // Pointer arithmetic
    logic          is_full;
    logic          ring_empty;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [SW-1:0] back_sum;
    logic [SW-1:0] back_wrap;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [CXW-1:0] cnt_ext;

    assign word_ext = XW'(value_in);

    // Capture the request beat and register the result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= dq_op_t'(opcode);
            word_reg <= word_ext[DATA_WIDTH-1:0];
        end
        status_reg <= status_next;
        vout_reg   <= vout_next;
    end

    // Queue state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Ring neighbors of the head and the two ends' slot indexes
    assign is_full    = (cnt_reg == FULL_CNT);
    assign ring_empty = (cnt_reg == '0);
    assign head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec   = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign back_sum   = SW'(head_reg) + SW'(cnt_reg);
    assign back_wrap  = (back_sum >= DEPTH_S) ? back_sum - DEPTH_S : back_sum;
    assign tail_sum   = back_sum - 1'b1;
    assign tail_wrap  = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;

    // Carry out the request
    always_comb
    begin
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        vout_next     = vout_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_addr      = head_reg;
        stat.rd_issue = 1'b0;

        if (cmd.exec)
        begin
            status_next = ST_DONE;
            vout_next   = '0;
            case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_addr  = head_dec;
                        ram_we    = 1'b1;
                        head_next = head_dec;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_addr = back_wrap[AW-1:0];
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                OP_POP_FRONT, OP_PEEK_FRONT:
                begin
                    if (ring_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ram_addr      = head_reg;
                        ram_re        = 1'b1;
                        stat.rd_issue = 1'b1;
                        if (op_reg == OP_POP_FRONT)
                        begin
                            head_next = head_inc;
                            cnt_next  = cnt_reg - 1'b1;
                        end
                    end
                end
                OP_POP_BACK, OP_PEEK_BACK:
                begin
                    if (ring_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ram_addr      = tail_wrap[AW-1:0];
                        ram_re        = 1'b1;
                        stat.rd_issue = 1'b1;
                        if (op_reg == OP_POP_BACK)
                        begin
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    head_next = '0;
                    cnt_next  = '0;
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end

        // Latch the word read from the ring
        if (cmd.take_rd)
        begin
            vout_next = rdata_ext[WORD_W-1:0];
        end
    end

    // Slot storage
    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (word_reg),
        .rdata (ram_rdata)
    );

    assign rdata_ext = XW'(ram_rdata);
    assign cnt_ext   = CXW'(cnt_reg);

    // Result fields
    assign value_out = vout_reg;
    assign status    = status_reg;
    assign count     = cnt_ext[COUNT_W-1:0];
    assign empty_res = ring_empty;

endmodule

// ===== src/double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core: double-ended queue of data words in a ring
// Push or pop at either end, peek at either end, or clear; one result beat
// for every request beat.
//
//   Channel | Dir | Payload                                   | Beat when
//   req     | in  | opcode, value_in                          | valid && ready
//   rsp     | out | value_out, status, count, empty_res        | valid && ready
//
// The result is valid once the sequencer has passed its exec state, and its
// read state too when it reads a slot, for the registered read of the
// single-port slot RAM. The sequencer goes back to idle after the result
// beat before it accepts another request.
// One request is in flight at a time; req.ready is high only when idle.
// A held result stalls the next request until rsp.ready takes it.
// Reset clears the head index and fill count at once; slots need no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);
    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    // Sequencer
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Pointers, slots and results
    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .opcode    (req.opcode),
        .value_in  (req.value_in),
        .value_out (rsp.value_out),
        .status    (rsp.status),
        .count     (rsp.count),
        .empty_res (rsp.empty_res)
    );

endmodule

// ===== tb/dq_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_result_checker: scoreboard for the double-ended queue core
// Watches the request and result channels. It tracks its own copy of the
// ring, head and fill count, works out the result of every request beat and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dq_result_checker (
    input  logic clk,
    input  logic rst_n,
    dq_req_if    req,
    dq_rsp_if    rsp,
    output int   mismatches,
    output int   awaiting
);
    import dq_pkg::*;

    localparam int RING      = DEPTH_DEF;
    localparam int IDX_W     = $clog2(RING);
    localparam int DUE_DEPTH = 64;

    typedef struct packed {
        logic [WORD_W-1:0]   value_out;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                empty_res;
    } dq_result_t;

    // Shadow of the queue contents
    logic [WORD_W-1:0]  ring [RING];
    logic [IDX_W-1:0]   front = '0;
    logic [COUNT_W-1:0] held  = '0;

    // Predictions waiting for their result beat, oldest at due_rd
    dq_result_t due_fifo [DUE_DEPTH];
    int         due_wr = 0;
    int         due_rd = 0;
    int         fails;

    // Apply one request to the shadow queue and return the result it must give
    task automatic apply_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                                 output dq_result_t res);
        logic [IDX_W-1:0] back;
        back = front + held[IDX_W-1:0] - 1'b1;
        res = '0;
        res.status = ST_DONE;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held == RING)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        front = front - 1'b1;
                        ring[front] = word;
                    end
                    else
                    begin
                        ring[front + held[IDX_W-1:0]] = word;
                    end
                    held = held + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK:
            begin
                if (held == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
                        res.value_out = ring[front];
                    else
                        res.value_out = ring[back];
                    // advance the head only on a front pop
                    if (op == OP_POP_FRONT)
                    begin
                        front = front + 1'b1;
                        held  = held - 1'b1;
                    end
                    else if (op == OP_POP_BACK)
                    begin
                        held = held - 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                front = '0;
                held  = '0;
            end
            default:
            begin
                // unused code: leave the queue as it is
            end
        endcase
        res.count     = held;
        res.empty_res = (held == 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        dq_result_t want;
        dq_result_t got;
        if (!rst_n)
        begin
            front  = '0;
            held   = '0;
            due_wr = 0;
            due_rd = 0;
            awaiting <= 0;
        end
        else
        begin
            // compare a result beat against the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                got.value_out = rsp.value_out;
                got.status    = rsp.status;
                got.count     = rsp.count;
                got.empty_res = rsp.empty_res;
                if (due_wr == due_rd)
                begin
                    $error("result beat with nothing outstanding: value_out=%h status=%0d",
                           got.value_out, got.status);
                    fails++;
                end
                else
                begin
                    want = due_fifo[due_rd % DUE_DEPTH];
                    due_rd++;
                    if (got.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %h, got %h", want.value_out, got.value_out);
                        fails++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        fails++;
                    end
                    if (got.empty_res !== want.empty_res)
                    begin
                        $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
                        fails++;
                    end
                end
            end
            // predict the result of a request beat
            if (req.valid && req.ready)
            begin
                apply_request(req.opcode, req.value_in, want);
                if (due_wr - due_rd >= DUE_DEPTH)
                begin
                    $error("too many results outstanding: %0d", due_wr - due_rd);
                    fails++;
                end
                else
                begin
                    due_fifo[due_wr % DUE_DEPTH] = want;
                    due_wr++;
                end
            end
            awaiting   <= due_wr - due_rd;
            mismatches <= fails;
        end
    end

endmodule

// ===== tb/tb_double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_core: testbench for the double-ended queue core
// Drives a directed run through full, empty and every opcode, then random
// segments that lean toward filling or draining the ring, with random gaps
// on both channels and one long result stall. A scoreboard checks every
// result beat.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_core;
    import dq_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 3'd7;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;
    int   cycles;
    int   beats_sent;
    bit   steady;    // no gaps on either channel
    bit   hold_rsp;  // long result stall in progress
    int   mismatches;
    int   awaiting;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dq_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pick an opcode; push_pct steers the ring toward full or empty
    function automatic logic [OP_W-1:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return ($urandom_range(0, 1) == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r == 99)
            return OP_NOP;
        if (r == 98)
            return OP_CLEAR;
        case ($urandom_range(0, 5))
            0, 1:    return OP_POP_FRONT;
            2, 3:    return OP_POP_BACK;
            4:       return OP_PEEK_FRONT;
            default: return OP_PEEK_BACK;
        endcase
    endfunction

    // Offer one request beat after an optional gap and hold it until taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.value_in <= word;
        do @(posedge clk); while (!req_ch.ready);
        beats_sent++;
    endtask

    // Stop the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stalls, none while steady
    initial
    begin : rsp_drive
        int stall_left;
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (!steady && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            rsp_ch.ready <= !hold_rsp && stall_left == 0;
        end
    end

    // Hold off results long enough to back up the request channel
    initial
    begin : rsp_hold_off
        hold_rsp = 1'b0;
        wait (beats_sent >= 300);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin : stimulus
        int push_pct;
        int seg_left;
        req_ch.valid    = 1'b0;
        req_ch.opcode   = OP_NOP;
        req_ch.value_in = '0;
        steady          = 1'b0;
        rst_n           = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the ring from both ends, extremes of the word first
        send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(OP_PUSH_BACK, 32'h0000_0000);
        for (int i = 2; i < DEPTH_DEF; i++)
            send_request((i % 2 == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom());

        // Push into a full ring at both ends
        send_request(OP_PUSH_FRONT, $urandom());
        send_request(OP_PUSH_BACK, $urandom());

        // Read both ends, then the unused code and a clear
        send_request(OP_PEEK_FRONT, $urandom());
        send_request(OP_PEEK_BACK, $urandom());
        send_request(OP_POP_FRONT, $urandom());
        send_request(OP_POP_BACK, $urandom());
        send_request(OP_NOP, $urandom());
        send_request(OP_CLEAR, $urandom());

        // Read from an empty queue
        send_request(OP_POP_BACK, $urandom());
        send_request(OP_PEEK_FRONT, $urandom());

        // Random segments leaning toward full, empty or balanced
        seg_left = 0;
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 120);
                case ($urandom_range(0, 2))
                    0:       push_pct = 70;
                    1:       push_pct = 30;
                    default: push_pct = 50;
                endcase
            end
            seg_left--;
            steady <= (n >= 500 && n < 600);
            send_request(pick_op(push_pct), $urandom());
        end
        req_ch.valid <= 1'b0;
        steady       <= 1'b0;

        // Drain outstanding results, then give the core time to settle
        do @(posedge clk); while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
